/* sv/rgl_pkg.sv */
// Package for the rotated grid line rasterizer: register indexes, field widths,
// the work item passed from front to back, and the queue width derived from it.
`timescale 1ns / 1ps
package rgl_pkg;
    localparam int CFG_W = 32;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_GRID_ORIGIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRID_EXTENT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROTATION      = 3'd2;
    localparam logic [IDX_W-1:0] REG_PATTERN       = 3'd3;
    localparam logic [IDX_W-1:0] REG_WINDOW_ORIGIN = 3'd4;
    localparam logic [IDX_W-1:0] REG_WINDOW_EXTENT = 3'd5;
    localparam logic [IDX_W-1:0] REG_DRAW_COLOR    = 3'd6;
    localparam int PIX_W = 11;
    localparam int FRAC_W = 15;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             has_plus;
        logic             has_minus;
    } job_t;

    localparam int JOB_W = $bits(job_t);
endpackage

/* sv/rgl_cfg.sv */
// Configuration register file for the rasterizer.
// Depends on rgl_pkg for register indexes.
`timescale 1ns / 1ps
module rgl_cfg
    import rgl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_data,
    output logic [31:0]      grid_origin,
    output logic [31:0]      grid_extent,
    output logic [31:0]      rotation,
    output logic [16:0]      pattern,
    output logic [31:0]      window_origin,
    output logic [31:0]      window_extent,
    output logic [23:0]      draw_color
);
    logic [31:0] go_reg, ge_reg, rot_reg, wo_reg, we_reg;
    logic [16:0] pat_reg;
    logic [23:0] col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg  <= 32'd0;
            ge_reg  <= 32'd67109888;
            rot_reg <= 32'd1073741824;
            pat_reg <= 17'd1;
            wo_reg  <= 32'd0;
            we_reg  <= 32'd134219776;
            col_reg <= 24'hFFFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GRID_ORIGIN:   go_reg  <= cfg_data;
                REG_GRID_EXTENT:   ge_reg  <= cfg_data;
                REG_ROTATION:      rot_reg <= cfg_data;
                REG_PATTERN:       pat_reg <= cfg_data[16:0];
                REG_WINDOW_ORIGIN: wo_reg  <= cfg_data;
                REG_WINDOW_EXTENT: we_reg  <= cfg_data;
                REG_DRAW_COLOR:    col_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign grid_origin   = go_reg;
    assign grid_extent   = ge_reg;
    assign rotation      = rot_reg;
    assign pattern       = pat_reg;
    assign window_origin = wo_reg;
    assign window_extent = we_reg;
    assign draw_color    = col_reg;
endmodule

/* sv/rgl_divmod.sv */
// Pipelined restoring divider, 17-bit dividend by 16-bit divisor, one
// quotient bit per stage, with a sideband that travels alongside.
`timescale 1ns / 1ps
module rgl_divmod #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [16:0]       dividend,
    input  logic [15:0]       divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [16:0]       quotient,
    output logic [15:0]       remainder,
    output logic [SIDE_W-1:0] out_side
);
    localparam int N = 17;
    logic [N:0]        v_reg;
    logic [16:0]       q_reg [N+1];
    logic [16:0]       r_reg [N+1];
    logic [15:0]       d_reg [N+1];
    logic [SIDE_W-1:0] s_reg [N+1];

    assign q_reg[0] = dividend;
    assign r_reg[0] = 17'd0;
    assign d_reg[0] = divisor;
    assign s_reg[0] = in_side;

    assign v_reg[0] = in_valid;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [17:0] trial;
        logic [16:0] q_i, r_i;
        logic [15:0] d_i;
        logic [SIDE_W-1:0] s_i;
        logic v_i;
        assign trial = {r_reg[i], q_reg[i][N-1]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_i <= 1'b0;
            else if (en)
                v_i <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {2'b00, d_reg[i]})
                begin
                    r_i <= 17'(trial - {2'b00, d_reg[i]});
                    q_i <= {q_reg[i][N-2:0], 1'b1};
                end
                else
                begin
                    r_i <= trial[16:0];
                    q_i <= {q_reg[i][N-2:0], 1'b0};
                end
                d_i <= d_reg[i];
                s_i <= s_reg[i];
            end
        end
        assign v_reg[i+1] = v_i;
        assign q_reg[i+1] = q_i;
        assign r_reg[i+1] = r_i;
        assign d_reg[i+1] = d_i;
        assign s_reg[i+1] = s_i;
    end

    assign out_valid = v_reg[N];
    assign quotient  = q_reg[N];
    assign remainder = r_reg[N][15:0];
    assign out_side  = s_reg[N];
endmodule

/* sv/rgl_front.sv */
// Front end: box test, grid test, rotation, clipping; one scan point per clock
// while en is high; emits a job per accepted point. Uses rgl_pkg, rgl_divmod.
`timescale 1ns / 1ps
module rgl_front
    import rgl_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 2048,
    parameter int IMAGE_HEIGHT = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [15:0] scan_x,
    input  logic [15:0] scan_y,
    input  logic [31:0] grid_origin,
    input  logic [31:0] grid_extent,
    input  logic [31:0] rotation,
    input  logic [16:0] pattern,
    input  logic [31:0] window_origin,
    input  logic [31:0] window_extent,
    output logic        job_valid,
    output job_t        job
);
    localparam int CW = 48;
    localparam logic signed [CW-1:0] IMG_W = CW'(IMAGE_WIDTH) <<< FRAC_W;
    localparam logic signed [CW-1:0] IMG_H = CW'(IMAGE_HEIGHT) <<< FRAC_W;
    localparam logic signed [CW-1:0] ONE   = CW'(1) <<< FRAC_W;

    logic signed [17:0] gx, gy, x, y, dx, dy;
    logic [15:0] w, h;
    logic [7:0]  sub, t;
    logic        in_box;

    assign gx  = 18'(signed'(grid_origin[31:16]));
    assign gy  = 18'(signed'(grid_origin[15:0]));
    assign x   = 18'(signed'(scan_x));
    assign y   = 18'(signed'(scan_y));
    assign w   = grid_extent[31:16];
    assign h   = grid_extent[15:0];
    assign sub = (pattern[7:0] == 8'd0) ? 8'd1 : pattern[7:0];
    assign t   = pattern[15:8];
    assign dx  = x - gx;
    assign dy  = y - gy;
    assign in_box = !dx[17] && !dy[17] &&
                    ({1'b0, dx} < 19'(w) + 19'(t)) &&
                    ({1'b0, dy} < 19'(h) + 19'(t));

    // stage 1: cell sizes via divider, plus box result
    typedef struct packed {
        logic        ok;
        logic [16:0] dx;
        logic [16:0] dy;
    } s1_t;
    s1_t s1_in;
    assign s1_in = '{ok: in_box, dx: dx[16:0], dy: dy[16:0]};

    logic        cw_v, ch_v;
    logic [16:0] cw_q, ch_q;
    logic [15:0] cw_r, ch_r;
    s1_t         s1_out, s1_unused;

    rgl_divmod #(.SIDE_W($bits(s1_t))) u_cw (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .dividend({1'b0, w}), .divisor({8'd0, sub}), .in_side(s1_in),
        .out_valid(cw_v), .quotient(cw_q), .remainder(cw_r), .out_side(s1_out));
    rgl_divmod #(.SIDE_W($bits(s1_t))) u_ch (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .dividend({1'b0, h}), .divisor({8'd0, sub}), .in_side(s1_in),
        .out_valid(ch_v), .quotient(ch_q), .remainder(ch_r), .out_side(s1_unused));

    logic [15:0] cw, ch;
    assign cw = (cw_q == 17'd0) ? 16'd1 : cw_q[15:0];
    assign ch = (ch_q == 17'd0) ? 16'd1 : ch_q[15:0];

    // stage 2: position within cell
    logic        mx_v, my_v;
    logic [16:0] mx_q, my_q;
    logic [15:0] mx_r, my_r;
    s1_t         s2, s2_unused;

    rgl_divmod #(.SIDE_W($bits(s1_t))) u_mx (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(cw_v),
        .dividend(s1_out.dx), .divisor(cw), .in_side(s1_out),
        .out_valid(mx_v), .quotient(mx_q), .remainder(mx_r), .out_side(s2));
    rgl_divmod #(.SIDE_W($bits(s1_t))) u_my (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(ch_v),
        .dividend(s1_out.dy), .divisor(ch), .in_side(s1_out),
        .out_valid(my_v), .quotient(my_q), .remainder(my_r), .out_side(s2_unused));

    logic grid_ok;
    assign grid_ok = s2.ok && ((pattern[16] && (mx_q[0] == my_q[0])) ||
                     (my_r <= 16'(t)) || (mx_r <= 16'(t)));

    // stage 3: products
    logic               p3_v;
    logic signed [CW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [18:0] px2, py2;
    logic signed [15:0] cs, sn;
    assign cs  = signed'(rotation[31:16]);
    assign sn  = signed'(rotation[15:0]);
    assign px2 = signed'({1'b0, s2.dx, 1'b0}) - signed'(19'(w));
    assign py2 = signed'({1'b0, s2.dy, 1'b0}) - signed'(19'(h));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_v <= 1'b0;
        else if (en)
            p3_v <= mx_v && my_v && grid_ok;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= CW'(cs * px2);
            b_reg <= CW'(sn * py2);
            c_reg <= CW'(sn * px2);
            d_reg <= CW'(cs * py2);
        end
    end

    // stage 4: sums and clip
    logic signed [CW-1:0] offx, offy, nx, ny, wxl, wxh, wyl, wyh;
    logic signed [17:0] wx, wy;
    assign offx = CW'(signed'({2'b00, w}) + (gx <<< 1)) <<< 14;
    assign offy = CW'(signed'({2'b00, h}) + (gy <<< 1)) <<< 14;
    assign nx   = a_reg - b_reg + offx;
    assign ny   = c_reg + d_reg + offy;
    assign wx   = 18'(signed'(window_origin[31:16]));
    assign wy   = 18'(signed'(window_origin[15:0]));
    assign wxl  = CW'(wx) <<< FRAC_W;
    assign wyl  = CW'(wy) <<< FRAC_W;
    assign wxh  = (CW'(wx) + CW'(window_extent[31:16]) + CW'(t)) <<< FRAC_W;
    assign wyh  = (CW'(wy) + CW'(window_extent[15:0])) <<< FRAC_W;

    logic clip_ok;
    assign clip_ok = nx > wxl && nx < wxh && ny > wyl && ny < wyh &&
                     nx > 0 && nx < IMG_W && ny > 0 && ny < IMG_H;

    logic v_reg;
    job_t job_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= p3_v && clip_ok;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            job_reg.px        <= nx[FRAC_W+PIX_W-1:FRAC_W];
            job_reg.py        <= ny[FRAC_W+PIX_W-1:FRAC_W];
            job_reg.has_plus  <= (nx + ONE < IMG_W) && (ny + ONE < IMG_H);
            job_reg.has_minus <= (nx > ONE) && (ny > ONE);
        end
    end

    assign job_valid = v_reg;
    assign job       = job_reg;
endmodule

/* sv/rgl_fifo.sv */
// Small job queue between the front and back ends, registered memory read.
// Depends on rgl_pkg for the job type.
`timescale 1ns / 1ps
module rgl_fifo
    import rgl_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    input  logic rd_en,
    output job_t rd_data,
    output logic empty,
    output logic [$clog2(DEPTH):0] count
);
    localparam int AW = $clog2(DEPTH);
    job_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg, rp_next;
    logic [AW:0]   cnt_reg;
    job_t          rd_reg;

    assign rp_next = rd_en ? AW'((32'(rp_reg) + 1) % DEPTH) : rp_reg;

    // head entry is read ahead into a register; a write to that slot is forwarded
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
        if (wr_en && (wp_reg == rp_next))
            rd_reg <= wr_data;
        else
            rd_reg <= mem[rp_next];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= AW'((32'(wp_reg) + 1) % DEPTH);
            rp_reg  <= rp_next;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end
    assign rd_data = rd_reg;
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
endmodule

/* sv/rgl_back.sv */
// Back end: expands one job into one, three or five pixel writes, with an
// output register. Depends on rgl_pkg.
`timescale 1ns / 1ps
module rgl_back
    import rgl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_take,
    input  logic [23:0] draw_color,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam logic [2:0] P_CENTER = 3'd0;
    localparam logic [2:0] P_YP     = 3'd1;
    localparam logic [2:0] P_XP     = 3'd2;
    localparam logic [2:0] P_YM     = 3'd3;
    localparam logic [2:0] P_XM     = 3'd4;

    logic [2:0]       ph_reg, ph_next;
    logic             ov_reg;
    logic [PIX_W-1:0] ox_reg, oy_reg;
    logic [23:0]      oc_reg;
    logic             ol_reg;
    logic             load, last;
    logic [PIX_W-1:0] x, y;

    assign load = job_valid && (!ov_reg || m_axis_tready);

    always_comb
    begin
        x = job.px;
        y = job.py;
        last = 1'b0;
        ph_next = ph_reg;
        case (ph_reg)
            P_CENTER:
            begin
                last = !job.has_plus && !job.has_minus;
                ph_next = job.has_plus ? P_YP : P_YM;
            end
            P_YP:     begin y = job.py + PIX_W'(1); ph_next = P_XP; end
            P_XP:
            begin
                x = job.px + PIX_W'(1);
                last = !job.has_minus;
                ph_next = P_YM;
            end
            P_YM:     begin y = job.py - PIX_W'(1); ph_next = P_XM; end
            P_XM:     begin x = job.px - PIX_W'(1); last = 1'b1; end
            default:  last = 1'b1;
        endcase
        if (last)
            ph_next = P_CENTER;
    end

    assign job_take = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= P_CENTER;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                ph_reg <= ph_next;
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
                ov_reg <= 1'b0;
        end
    end
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ox_reg <= x;
            oy_reg <= y;
            oc_reg <= draw_color;
            ol_reg <= last;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {2'b00, oc_reg, oy_reg, ox_reg};
    assign m_axis_tlast  = ol_reg;
endmodule

/* sv/rotated_grid_line_rasterizer.sv */
// Top level of the rotated grid line rasterizer.
// Depends on rgl_pkg, rgl_cfg, rgl_front, rgl_fifo, rgl_back.
// Accepts one scan point per clock while s_axis_tready is high; a point reaches the job
// queue through two 17-stage dividers (cell size, then position in cell), the product
// and clip stages. The back end writes one pixel per clock while the sink is ready,
// so a point yields 1, 3 or 5 pixel writes. The input stalls when the job queue count
// plus LAT reaches DEPTH, which keeps room for every point still in the front pipeline.
`timescale 1ns / 1ps
module rotated_grid_line_rasterizer
    import rgl_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 2048,
    parameter int IMAGE_HEIGHT = 2048
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,   // scan_x[15:0], scan_y[31:16]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // pixel_x[10:0], pixel_y[21:11], pixel_color[45:22]
    output logic             m_axis_tlast,   // last_write
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_data
);
    localparam int DEPTH = 64;
    localparam int LAT   = 40;

    logic [31:0] go, ge, rot, wo, we;
    logic [16:0] pat;
    logic [23:0] col;

    rgl_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_data(cfg_data), .grid_origin(go), .grid_extent(ge), .rotation(rot),
        .pattern(pat), .window_origin(wo), .window_extent(we), .draw_color(col));

    logic job_valid, job_take, q_empty;
    job_t job, q_job;
    logic [$clog2(DEPTH):0] q_count;

    // front always advances; stall input when queue could overflow
    assign s_axis_tready = (32'(q_count) + LAT) < DEPTH;

    rgl_front #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n), .en(1'b1),
        .in_valid(s_axis_tvalid && s_axis_tready),
        .scan_x(s_axis_tdata[15:0]), .scan_y(s_axis_tdata[31:16]),
        .grid_origin(go), .grid_extent(ge), .rotation(rot), .pattern(pat),
        .window_origin(wo), .window_extent(we),
        .job_valid(job_valid), .job(job));

    rgl_fifo #(.DEPTH(DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_en(job_valid), .wr_data(job),
        .rd_en(job_take), .rd_data(q_job), .empty(q_empty), .count(q_count));

    rgl_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(!q_empty), .job(q_job),
        .job_take(job_take), .draw_color(col),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast));
endmodule

/* sv/rgl_checker.sv */
// Port-level checker for the rasterizer, bound to the top level.
// Depends on rgl_pkg.
`timescale 1ns / 1ps
module rgl_checker
    import rgl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:46] == 2'b00)
        else $error("tdata padding not zero");
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");
    a_ready_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> s_axis_tready)
        else $error("input not ready after reset");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid)
        else $error("input transaction withdrawn while stalled");
endmodule

bind rotated_grid_line_rasterizer rgl_checker u_rgl_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast));

/* tb/sv/rgl_checker.sv */
// Checker for the rotated grid line rasterizer: mirrors the register file,
// predicts the pixel writes of every accepted scan point and compares them.
// Depends on rgl_pkg.
`timescale 1ns / 1ps
module rgl_scoreboard
    import rgl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [47:0]      m_axis_tdata,
    input  logic             m_axis_tlast,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    typedef struct packed {
        logic [10:0] px;
        logic [10:0] py;
        logic [23:0] color;
        logic        last;
    } pixel_write_t;

    localparam longint SUB = 32768;
    localparam longint IMG_W = 2048;
    localparam longint IMG_H = 2048;

    logic [31:0] grid_org, grid_ext, rot, win_org, win_ext;
    logic [16:0] pat;
    logic [23:0] color;
    pixel_write_t pixel_q[$];

    assign pending = pixel_q.size();

    function automatic longint s16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic pixel_write_t mk(longint x, longint y);
        pixel_write_t p;
        p.px = x[10:0];
        p.py = y[10:0];
        p.color = color;
        p.last = 1'b0;
        return p;
    endfunction

    task automatic rasterize(logic [15:0] sxv, logic [15:0] syv);
        longint x, y, gx, gy, w, h, cs, sn, sb, t, wx, wy, ww, wh;
        longint dx, dy, cw, ch, nx, ny, pxi, pyi;
        bit chk, hit;
        pixel_write_t burst[$];
        x = s16(sxv); y = s16(syv);
        gx = s16(grid_org[31:16]); gy = s16(grid_org[15:0]);
        w = grid_ext[31:16]; h = grid_ext[15:0];
        cs = s16(rot[31:16]); sn = s16(rot[15:0]);
        sb = pat[7:0]; t = pat[15:8]; chk = pat[16];
        wx = s16(win_org[31:16]); wy = s16(win_org[15:0]);
        ww = win_ext[31:16]; wh = win_ext[15:0];
        if (sb < 1) sb = 1;
        if (x < gx || x > gx + w + t - 1 || y < gy || y > gy + h + t - 1) return;
        dx = x - gx; dy = y - gy;
        cw = w / sb; ch = h / sb;
        if (cw < 1) cw = 1;
        if (ch < 1) ch = 1;
        hit = (dy % ch) <= t || (dx % cw) <= t;
        if (chk && (((dy / ch) & 1) == ((dx / cw) & 1))) hit = 1;
        if (!hit) return;
        nx = cs * (2 * dx - w) - sn * (2 * dy - h) + 16384 * (w + 2 * gx);
        ny = sn * (2 * dx - w) + cs * (2 * dy - h) + 16384 * (h + 2 * gy);
        if (!(nx > wx * SUB && nx < (wx + ww + t) * SUB &&
              ny > wy * SUB && ny < (wy + wh) * SUB)) return;
        if (!(nx > 0 && nx < IMG_W * SUB && ny > 0 && ny < IMG_H * SUB)) return;
        pxi = nx / SUB; pyi = ny / SUB;
        burst = {burst, mk(pxi, pyi)};
        if (nx + SUB < IMG_W * SUB && ny + SUB < IMG_H * SUB) begin
            burst = {burst, mk(pxi, pyi + 1)};
            burst = {burst, mk(pxi + 1, pyi)};
        end
        if (nx > SUB && ny > SUB) begin
            burst = {burst, mk(pxi, pyi - 1)};
            burst = {burst, mk(pxi - 1, pyi)};
        end
        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) pixel_q = {pixel_q, burst[i]};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_write_t e;
        if (!rst_n)
        begin
            grid_org = 0; grid_ext = 32'd67109888; rot = 32'd1073741824;
            pat = 17'd1; win_org = 0; win_ext = 32'd134219776; color = 24'hFFFFFF;
            fail_count = 0;
            pixel_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $error("unexpected pixel transaction %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    e = pixel_q.pop_front();
                    if (m_axis_tdata[10:0] !== e.px)
                    begin
                        $error("pixel_x exp %0d got %0d", e.px, m_axis_tdata[10:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[21:11] !== e.py)
                    begin
                        $error("pixel_y exp %0d got %0d", e.py, m_axis_tdata[21:11]);
                        fail_count++;
                    end
                    if (m_axis_tdata[45:22] !== e.color)
                    begin
                        $error("pixel_color exp %h got %h", e.color, m_axis_tdata[45:22]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== e.last)
                    begin
                        $error("last_write exp %0d got %0d", e.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                rasterize(s_axis_tdata[15:0], s_axis_tdata[31:16]);
            if (cfg_we)
                case (cfg_addr)
                    REG_GRID_ORIGIN:   grid_org = cfg_data;
                    REG_GRID_EXTENT:   grid_ext = cfg_data;
                    REG_ROTATION:      rot = cfg_data;
                    REG_PATTERN:       pat = cfg_data[16:0];
                    REG_WINDOW_ORIGIN: win_org = cfg_data;
                    REG_WINDOW_EXTENT: win_ext = cfg_data;
                    REG_DRAW_COLOR:    color = cfg_data[23:0];
                    default: ;
                endcase
        end
    end
endmodule

/* tb/sv/rotated_grid_line_rasterizer_tb.sv */
// Testbench top for the rotated grid line rasterizer: drives scan points and
// register phases with random idling. Depends on rgl_pkg, rgl_scoreboard and the RTL.
`timescale 1ns / 1ps
module rotated_grid_line_rasterizer_tb;
    import rgl_pkg::*;

    logic clk, rst_n;
    logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [31:0] s_axis_tdata;
    logic [47:0] m_axis_tdata;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_data;
    int fail_count, pending, cycles, sent;
    bit calm;

    rotated_grid_line_rasterizer i_dut (.*);
    rgl_scoreboard i_chk (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sink stalls
    initial
    begin
        int n;
        m_axis_tready = 1;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 18);
                m_axis_tready = 0;
                repeat (n) @(negedge clk);
                m_axis_tready = 1;
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] a, logic [31:0] d);
        cfg_we = 1; cfg_addr = a; cfg_data = d;
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic send_scan(logic [15:0] sxv, logic [15:0] syv);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid = 0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = {syv, sxv};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 0;
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid = 0;
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // random point near the grid box so most land on lines
    task automatic near_scan(int gx, int gy, int span);
        send_scan(16'(gx + $urandom_range(0, span) - 4), 16'(gy + $urandom_range(0, span) - 4));
    endtask

    initial
    begin
        logic [31:0] v;
        s_axis_tvalid = 0; s_axis_tdata = 0;
        cfg_we = 0; cfg_addr = REG_GRID_ORIGIN; cfg_data = 0;
        rst_n = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // reset settings: corners, edges, extremes
        send_scan(16'd0, 16'd0);
        send_scan(16'd1, 16'd1);
        send_scan(16'd0, 16'd500);
        send_scan(16'd1023, 16'd0);
        send_scan(16'd2047, 16'd2047);
        send_scan(16'h7FFF, 16'h7FFF);
        send_scan(16'h8000, 16'h8000);
        send_scan(16'hFFFF, 16'd0);
        send_scan(16'd100, 16'd1023);
        drain();

        // checker mode, zero subdivisions, 45 degrees, offset boxes
        write_reg(REG_GRID_ORIGIN, {16'd100, 16'd200});
        write_reg(REG_GRID_EXTENT, {16'd300, 16'd200});
        write_reg(REG_ROTATION, {16'd11585, 16'd11585});
        write_reg(REG_PATTERN, {1'b1, 8'd2, 8'd0});
        write_reg(REG_WINDOW_ORIGIN, {16'd10, 16'd10});
        write_reg(REG_WINDOW_EXTENT, {16'd900, 16'd900});
        write_reg(REG_DRAW_COLOR, 32'h0012AB34);
        send_scan(16'd100, 16'd200);
        send_scan(16'd250, 16'd300);
        send_scan(16'd401, 16'd401);
        send_scan(16'd150, 16'd250);
        drain();

        // zero cell size, negative rotation and origins, extreme color
        write_reg(REG_GRID_ORIGIN, {16'hFFF0, 16'hFFF0});
        write_reg(REG_GRID_EXTENT, {16'd3, 16'd2});
        write_reg(REG_ROTATION, {16'h8000, 16'h7FFF});
        write_reg(REG_PATTERN, {1'b0, 8'hFF, 8'hFF});
        write_reg(REG_WINDOW_ORIGIN, {16'h8000, 16'h8000});
        write_reg(REG_WINDOW_EXTENT, 32'hFFFFFFFF);
        write_reg(REG_DRAW_COLOR, 32'h0);
        send_scan(16'hFFF0, 16'hFFF0);
        send_scan(16'd5, 16'd7);
        send_scan(16'd200, 16'd200);
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            int gx, gy, sp;
            calm = (ph == 7);
            gx = $urandom_range(0, 1500); gy = $urandom_range(0, 1500);
            sp = $urandom_range(8, 400);
            write_reg(REG_GRID_ORIGIN, {16'(gx), 16'(gy)});
            write_reg(REG_GRID_EXTENT, {16'($urandom_range(0, sp)), 16'($urandom_range(0, sp))});
            v = $urandom;
            write_reg(REG_ROTATION, ($urandom_range(0, 1)) ? {16'd16384, 16'd0} : v);
            write_reg(REG_PATTERN, {1'($urandom), 8'($urandom_range(0, 6)),
                                   8'($urandom_range(0, 12))});
            write_reg(REG_WINDOW_ORIGIN, ($urandom_range(0, 2) == 0) ? $urandom : 32'd0);
            write_reg(REG_WINDOW_EXTENT, ($urandom_range(0, 2) == 0) ? $urandom : 32'h08000800);
            write_reg(REG_DRAW_COLOR, $urandom);
            repeat (25)
                if ($urandom_range(0, 4) == 0) send_scan(16'($urandom), 16'($urandom));
                else near_scan(gx, gy, sp + 8);
            drain();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
